[rtl/core/arx_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// arx_pkg - shared types, constants and byte-permutation helpers
// Item structs, sequencer states, register codes and the transpose and
// shuffle functions used by the 16-byte ARX cipher block.
// ============================================================================
package arx_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int BLOCK_W     = 8 * BLOCK_BYTES;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 64;
    localparam int ROT_AMT     = 5;

    // Register codes, taken from paddr[4:3]
    localparam logic [1:0] REG_KEY_LOW     = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH    = 2'd1;
    localparam logic [1:0] REG_ROUND_COUNT = 2'd2;

    localparam logic [7:0] ROUND_COUNT_RESET = 8'd1;

    // Destination byte of each source byte in the forward shuffle
    localparam logic [3:0] SHUF_DST [BLOCK_BYTES] = '{
        4'd7, 4'd12, 4'd14, 4'd9, 4'd2, 4'd1, 4'd5, 4'd15,
        4'd11, 4'd6, 4'd13, 4'd0, 4'd4, 4'd8, 4'd10, 4'd3
    };

    typedef struct packed {
        logic        func;
        logic [63:0] block_lo;
        logic [63:0] block_hi;
    } req_t;

    typedef struct packed {
        logic [63:0] result_lo;
        logic [63:0] result_hi;
    } rsp_t;

    typedef struct packed {
        logic [BLOCK_W-1:0] key;
        logic [7:0]         rounds;
    } cfg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PERM,
        S_MIX,
        S_DONE
    } state_t;

    // 8x8 bit matrix transpose: out row r, column c = in row c, column r
    function automatic logic [63:0] transpose8(input logic [63:0] m);
        logic [63:0] t;
        t = '0;
        for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
                t[8*r + c] = m[8*c + r];
            end
        end
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] transpose_lo(input logic [BLOCK_W-1:0] b);
        return {b[BLOCK_W-1:64], transpose8(b[63:0])};
    endfunction

    function automatic logic [BLOCK_W-1:0] transpose_both(input logic [BLOCK_W-1:0] b);
        return {transpose8(b[BLOCK_W-1:64]), transpose8(b[63:0])};
    endfunction

    function automatic logic [BLOCK_W-1:0] shuffle_fwd(input logic [BLOCK_W-1:0] b);
        logic [BLOCK_W-1:0] t;
        t = '0;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            t[8*SHUF_DST[i] +: 8] = b[8*i +: 8];
        end
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] shuffle_inv(input logic [BLOCK_W-1:0] b);
        logic [BLOCK_W-1:0] t;
        t = '0;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            t[8*i +: 8] = b[8*SHUF_DST[i] +: 8];
        end
        return t;
    endfunction

    function automatic logic [7:0] xor_all(input logic [BLOCK_W-1:0] b);
        logic [7:0] s;
        s = '0;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            s = s ^ b[8*i +: 8];
        end
        return s;
    endfunction

endpackage

[rtl/core/arx_cfg_regs.sv]
`timescale 1ns / 1ps
// ============================================================================
// arx_cfg_regs - APB configuration registers
// Holds the 128-bit key and the round count; registers sit at 8-byte steps.
// ============================================================================
module arx_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [arx_pkg::PADDR_W-1:0] paddr,
    input  logic [arx_pkg::PDATA_W-1:0] pwdata,
    output logic [arx_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output arx_pkg::cfg_t               cfg
);
    import arx_pkg::*;

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic [7:0]  rounds_reg;
    logic [1:0]  reg_idx;
    logic        wr_en;

    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            rounds_reg   <= ROUND_COUNT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_KEY_LOW:     key_low_reg  <= pwdata;
                REG_KEY_HIGH:    key_high_reg <= pwdata;
                REG_ROUND_COUNT: rounds_reg   <= pwdata[7:0];
                default:         ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KEY_LOW:     prdata = key_low_reg;
            REG_KEY_HIGH:    prdata = key_high_reg;
            REG_ROUND_COUNT: prdata = {{(PDATA_W-8){1'b0}}, rounds_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.key    = {key_high_reg, key_low_reg};
    assign cfg.rounds = rounds_reg;

endmodule

[rtl/core/arx_mix_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// arx_mix_unit - shared add-rotate-xor byte-pair mix
// Forward or inverse mix of one left/right byte pair with one key byte.
// ============================================================================
module arx_mix_unit (
    input  logic       inv,
    input  logic [7:0] run,
    input  logic [7:0] kb,
    input  logic [7:0] l_in,
    input  logic [7:0] r_in,
    output logic [7:0] l_out,
    output logic [7:0] r_out
);
    import arx_pkg::*;

    function automatic logic [7:0] rotl5(input logic [7:0] x);
        return {x[7-ROT_AMT:0], x[7:8-ROT_AMT]};
    endfunction

    logic [7:0] run1;
    logic [7:0] r_fwd;
    logic [7:0] l_fwd;
    logic [7:0] l_inv;

    assign run1 = run ^ l_in ^ r_in;

    // Forward: add into right, then fold right back into left
    assign r_fwd = r_in + run1 + kb;
    assign l_fwd = (l_in + {4'd0, r_fwd[7:4]}) ^ rotl5(r_fwd);

    // Inverse: undo the left fold first, then the right add
    assign l_inv = (l_in ^ rotl5(r_in)) - {4'd0, r_in[7:4]};

    assign l_out = inv ? l_inv : l_fwd;
    assign r_out = inv ? (r_in - run1 - kb) : r_fwd;

endmodule

[rtl/core/arx_block_cipher_16byte.sv]
`timescale 1ns / 1ps
// ============================================================================
// arx_block_cipher_16byte - iterative 16-byte ARX block cipher
// Encrypts or decrypts one block per item with the configured key and rounds.
// ============================================================================
// One item is worked at a time. A round is one permute step for the
// half transposes and byte shuffle and sixteen mix steps in which the single
// shared pair-mix unit handles one byte pair per cycle; decrypt mixes first
// and permutes after. The finishing state holds while the previous result
// still waits on rsp_stall. The result sits in its own register, so the
// next item may be accepted while the last result still waits on rsp_stall.
// Key and round count are written through the APB port (key_low at 0x00,
// key_high at 0x08, round_count at 0x10) and must only change while no
// item is in flight.
// ============================================================================
module arx_block_cipher_16byte (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [arx_pkg::PADDR_W-1:0] paddr,
    input  logic [arx_pkg::PDATA_W-1:0] pwdata,
    output logic [arx_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    // request channel
    input  logic                        req_valid,
    output logic                        req_stall,
    input  arx_pkg::req_t               req,
    // response channel
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output arx_pkg::rsp_t               rsp
);
    import arx_pkg::*;

    cfg_t               cfg;

    state_t             state_reg, state_next;
    logic [BLOCK_W-1:0] blk_reg, blk_next;
    logic               dec_reg, dec_next;
    logic [7:0]         rnd_reg, rnd_next;
    logic [3:0]         pair_reg, pair_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic [BLOCK_W-1:0] req_blk;
    logic [3:0]         left_idx;
    logic [7:0]         mix_l, mix_r;
    logic [7:0]         run;
    logic               step_last;
    logic               out_free;
    logic [BLOCK_W-1:0] fin_blk;

    arx_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The running byte of the chain always equals the XOR of all block
    // bytes, so derive it from the block instead of carrying it.
    assign run       = xor_all(blk_reg);
    assign left_idx  = pair_reg - 4'd1;     // pair 0 wraps to (15, 0)
    assign step_last = dec_reg ? (pair_reg == 4'hF) : (pair_reg == 4'h0);

    arx_mix_unit u_mix (
        .inv   (dec_reg),
        .run   (run),
        .kb    (cfg.key[8*pair_reg +: 8]),
        .l_in  (blk_reg[8*left_idx +: 8]),
        .r_in  (blk_reg[8*pair_reg +: 8]),
        .l_out (mix_l),
        .r_out (mix_r)
    );

    assign req_blk  = {req.block_hi, req.block_lo};
    assign out_free = !rsp_valid_reg || !rsp_stall;
    // Decrypt finishes with the low-half transpose and the key XOR
    assign fin_blk  = dec_reg ? (transpose_lo(blk_reg) ^ cfg.key) : blk_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        blk_reg  <= blk_next;
        dec_reg  <= dec_next;
        rnd_reg  <= rnd_next;
        pair_reg <= pair_next;
        rsp_reg  <= rsp_next;
    end

    always_comb begin
        state_next     = state_reg;
        blk_next       = blk_reg;
        dec_next       = dec_reg;
        rnd_next       = rnd_reg;
        pair_next      = pair_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        req_stall      = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid) begin
                    dec_next = req.func;
                    rnd_next = cfg.rounds;
                    if (!req.func) begin
                        // whitening and first-half transpose, then rounds
                        blk_next   = transpose_lo(req_blk ^ cfg.key);
                        state_next = (cfg.rounds == 8'd0) ? S_DONE : S_PERM;
                    end else begin
                        blk_next   = req_blk;
                        pair_next  = 4'h0;
                        state_next = (cfg.rounds == 8'd0) ? S_DONE : S_MIX;
                    end
                end
            end
            S_PERM:
            begin
                if (!dec_reg) begin
                    blk_next   = shuffle_fwd(transpose_both(blk_reg));
                    pair_next  = 4'hF;
                    state_next = S_MIX;
                end else begin
                    // close a decrypt round
                    blk_next   = transpose_both(shuffle_inv(blk_reg));
                    rnd_next   = rnd_reg - 8'd1;
                    pair_next  = 4'h0;
                    state_next = (rnd_reg == 8'd1) ? S_DONE : S_MIX;
                end
            end
            S_MIX:
            begin
                blk_next                 = blk_reg;
                blk_next[8*left_idx +: 8] = mix_l;
                blk_next[8*pair_reg +: 8] = mix_r;
                if (step_last) begin
                    if (!dec_reg) begin
                        rnd_next   = rnd_reg - 8'd1;
                        state_next = (rnd_reg == 8'd1) ? S_DONE : S_PERM;
                    end else begin
                        state_next = S_PERM;
                    end
                end else begin
                    // encrypt walks pairs downward, decrypt upward
                    pair_next = dec_reg ? (pair_reg + 4'd1) : (pair_reg - 4'd1);
                end
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (out_free) begin
                    rsp_next.result_lo = fin_blk[63:0];
                    rsp_next.result_hi = fin_blk[BLOCK_W-1:64];
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Mixing only runs with at least one round left
    a_mix_has_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX) |-> (rnd_reg != 8'd0))
        else $error("mix step with no round left");

    // The last pair of a chain always leaves the mix state
    a_chain_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX && step_last) |=> (state_reg != S_MIX))
        else $error("mix chain ran past its last pair");

    // A new result appears only out of the finishing state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !$past(rsp_valid_reg)) |-> ($past(state_reg) == S_DONE))
        else $error("result loaded outside the finishing state");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the 16-byte ARX block cipher
// Drives encrypt and decrypt blocks through the valid/stall request channel
// under bursty traffic and a wandering response stall. Every accepted result
// is matched in order against a typed-in value or a bit-exact software model
// of the cipher, across several key and round-count settings written over APB.
// ----------------------------------------------------------------------------
module tb;

    import arx_pkg::*;

    localparam int          ITEM_TARGET = 2000;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int          NUM_VECTORS = 23;

    // Operation codes carried in req.func
    localparam logic FUNC_ENC = 1'b0;
    localparam logic FUNC_DEC = 1'b1;

    // Register code with no register behind it; writes there must be ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic [63:0] ZERO = 64'h0;
    localparam logic [63:0] ONES = {64{1'b1}};

    // Directed rows either carry a typed-in result or defer to the model
    localparam logic TYPED = 1'b1;
    localparam logic MODEL = 1'b0;

    // Destination byte of each source byte in the round shuffle, byte 0 lowest
    localparam logic [63:0] BYTE_DEST = {
        4'd3, 4'd10, 4'd8, 4'd4, 4'd0, 4'd13, 4'd6, 4'd11,
        4'd15, 4'd5, 4'd1, 4'd2, 4'd9, 4'd14, 4'd12, 4'd7
    };

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_RUNS
    } stall_mode_t;

    typedef struct packed {
        logic [7:0]  rounds;
        logic        op;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        typed;
        logic [63:0] want_lo;
        logic [63:0] want_hi;
    } vector_t;

    // Directed blocks, grouped by round count; the key stays at its reset value
    vector_t vectors [NUM_VECTORS] = '{
        // one round (reset setting): an all-zero block stays zero under a zero key
        {8'd1, FUNC_ENC, ZERO, ZERO, TYPED, ZERO, ZERO},
        {8'd1, FUNC_DEC, ZERO, ZERO, TYPED, ZERO, ZERO},
        {8'd1, FUNC_ENC, ONES, ONES, MODEL, ZERO, ZERO},
        {8'd1, FUNC_DEC, ONES, ONES, MODEL, ZERO, ZERO},
        {8'd1, FUNC_ENC, 64'h1, ZERO, MODEL, ZERO, ZERO},
        {8'd1, FUNC_ENC, ZERO, 64'h8000_0000_0000_0000, MODEL, ZERO, ZERO},
        {8'd1, FUNC_DEC, 64'h8000_0000_0000_0000, 64'h1, MODEL, ZERO, ZERO},
        {8'd1, FUNC_ENC, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
         MODEL, ZERO, ZERO},
        {8'd1, FUNC_DEC, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
         MODEL, ZERO, ZERO},
        {8'd1, FUNC_ENC, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
         MODEL, ZERO, ZERO},
        // zero rounds: only the low-half transpose acts under a zero key
        {8'd0, FUNC_ENC, ZERO, ZERO, TYPED, ZERO, ZERO},
        {8'd0, FUNC_ENC, ONES, ONES, TYPED, ONES, ONES},
        {8'd0, FUNC_DEC, ONES, ZERO, TYPED, ONES, ZERO},
        {8'd0, FUNC_DEC, ZERO, ONES, TYPED, ZERO, ONES},
        {8'd0, FUNC_ENC, 64'h1, 64'h1234, TYPED, 64'h1, 64'h1234},
        {8'd0, FUNC_ENC, 64'h80, ZERO, MODEL, ZERO, ZERO},
        {8'd0, FUNC_DEC, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
         MODEL, ZERO, ZERO},
        // maximum round count
        {8'd255, FUNC_ENC, ZERO, ZERO, TYPED, ZERO, ZERO},
        {8'd255, FUNC_DEC, ZERO, ZERO, TYPED, ZERO, ZERO},
        {8'd255, FUNC_ENC, ONES, ZERO, MODEL, ZERO, ZERO},
        {8'd255, FUNC_DEC, ZERO, ONES, MODEL, ZERO, ZERO},
        // two rounds, same block both ways
        {8'd2, FUNC_ENC, 64'hdead_beef_0bad_f00d, 64'h1357_9bdf_2468_ace0,
         MODEL, ZERO, ZERO},
        {8'd2, FUNC_DEC, 64'hdead_beef_0bad_f00d, 64'h1357_9bdf_2468_ace0,
         MODEL, ZERO, ZERO}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                req_valid;
    logic                req_stall;
    req_t                req;
    logic                rsp_valid;
    logic                rsp_stall;
    rsp_t                rsp;

    // Shadow of the cipher registers, kept in step with every APB write
    logic [63:0] cur_key_lo;
    logic [63:0] cur_key_hi;
    logic [7:0]  cur_rounds;

    // Results still owed by the block, oldest first
    rsp_t        pending_results[$];
    rsp_t        oldest;

    // Typed-in result that travels with the block on the request channel
    logic        pend_typed;
    rsp_t        pend_want;

    int          burst_left;
    int          fail_cnt;
    int          blocks_sent;
    int          enc_cnt;
    int          dec_cnt;
    int          checked_cnt;
    int          setting_cnt;
    int unsigned cycle_cnt;

    stall_mode_t stall_mode;
    int          mode_left;
    int          run_left;
    logic        stall_run;

    arx_block_cipher_16byte i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Cipher model
    // ------------------------------------------------------------------

    // 8x8 bit matrix transpose, byte k is row k; it undoes itself
    function automatic logic [63:0] flip8x8(input logic [63:0] m);
        logic [63:0] t;
        for (int row = 0; row < 8; row++)
        begin
            for (int col = 0; col < 8; col++)
            begin
                t[8*row + col] = m[8*col + row];
            end
        end
        return t;
    endfunction

    function automatic logic [7:0] fold_bytes(input logic [127:0] blk);
        logic [7:0] s;
        s = 8'h0;
        for (int i = 0; i < 16; i++)
        begin
            s = s ^ blk[8*i +: 8];
        end
        return s;
    endfunction

    // Full encryption or decryption of one block. The sixteen pair mixes of
    // a round are numbered j = 0..15: pairs (14,15) down to (0,1), then the
    // wrap-around pair (15,0). The right byte's index picks the key byte.
    // Decryption walks the same chain backward with each mix inverted.
    function automatic rsp_t cipher_block(input logic op, input logic [63:0] lo,
                                          input logic [63:0] hi, input logic [127:0] key,
                                          input logic [7:0] rounds);
        logic [127:0] blk;
        logic [127:0] tmp;
        logic [7:0]   run;
        logic [7:0]   l;
        logic [7:0]   r;
        logic [7:0]   kb;
        int           li;
        int           ri;
        int           d;
        rsp_t         res;
        blk = {hi, lo};
        if (op == FUNC_ENC)
        begin
            blk = blk ^ key;
            blk[63:0] = flip8x8(blk[63:0]);
            for (int n = 0; n < rounds; n++)
            begin
                blk = {flip8x8(blk[127:64]), flip8x8(blk[63:0])};
                for (int i = 0; i < 16; i++)
                begin
                    d = int'(BYTE_DEST[4*i +: 4]);
                    tmp[8*d +: 8] = blk[8*i +: 8];
                end
                blk = tmp;
                run = fold_bytes(blk);
                for (int j = 0; j < 16; j++)
                begin
                    li = (j < 15) ? 14 - j : 15;
                    ri = (j < 15) ? 15 - j : 0;
                    l  = blk[8*li +: 8];
                    r  = blk[8*ri +: 8];
                    kb = key[8*ri +: 8];
                    run = run ^ l ^ r;
                    r = r + run + kb;
                    l = l + (r >> 4);
                    l = l ^ {r[2:0], r[7:3]};
                    run = run ^ l ^ r;
                    blk[8*li +: 8] = l;
                    blk[8*ri +: 8] = r;
                end
            end
        end
        else
        begin
            for (int n = 0; n < rounds; n++)
            begin
                run = fold_bytes(blk);
                for (int j = 15; j >= 0; j--)
                begin
                    li = (j < 15) ? 14 - j : 15;
                    ri = (j < 15) ? 15 - j : 0;
                    l  = blk[8*li +: 8];
                    r  = blk[8*ri +: 8];
                    kb = key[8*ri +: 8];
                    run = run ^ l ^ r;
                    l = l ^ {r[2:0], r[7:3]};
                    l = l - (r >> 4);
                    r = r - run - kb;
                    run = run ^ l ^ r;
                    blk[8*li +: 8] = l;
                    blk[8*ri +: 8] = r;
                end
                for (int i = 0; i < 16; i++)
                begin
                    d = int'(BYTE_DEST[4*i +: 4]);
                    tmp[8*i +: 8] = blk[8*d +: 8];
                end
                blk = {flip8x8(tmp[127:64]), flip8x8(tmp[63:0])};
            end
            blk[63:0] = flip8x8(blk[63:0]);
            blk = blk ^ key;
        end
        res.result_lo = blk[63:0];
        res.result_hi = blk[127:64];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // APB access
    // ------------------------------------------------------------------

    // Setup phase, then access phase until pready. Starts and ends at a falling
    // edge with psel already low, so back-to-back calls never retarget psel in one step.
    task automatic apb_transfer(input logic wr, input logic [1:0] code,
                                input logic [63:0] data, output logic [63:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {code, 3'b000};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] code, input logic [63:0] data);
        logic [63:0] unused;
        apb_transfer(1'b1, code, data, unused);
        case (code)
            REG_KEY_LOW:     cur_key_lo = data;
            REG_KEY_HIGH:    cur_key_hi = data;
            REG_ROUND_COUNT: cur_rounds = data[7:0];
            default:         ;
        endcase
    endtask

    task automatic check_reg(input logic [1:0] code, input logic [63:0] want_val,
                             input string name);
        logic [63:0] got;
        apb_transfer(1'b0, code, ZERO, got);
        if (got !== want_val)
        begin
            $error("%s readback: expected %h, actual %h", name, want_val, got);
            fail_cnt++;
        end
    endtask

    // Load a full setting: junk above the round count and a stray write to
    // the unused code must both leave no trace. Read everything back.
    task automatic load_cipher(input logic [63:0] klo, input logic [63:0] khi,
                               input logic [7:0] rounds);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_KEY_LOW, klo);
        write_reg(REG_KEY_HIGH, khi);
        write_reg(REG_ROUND_COUNT, {junk[63:8], rounds});
        write_reg(REG_UNUSED, {$urandom, $urandom});
        check_reg(REG_KEY_LOW, cur_key_lo, "key_low");
        check_reg(REG_KEY_HIGH, cur_key_hi, "key_high");
        check_reg(REG_ROUND_COUNT, {56'h0, cur_rounds}, "round_count");
        setting_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one block and hold it until accepted. Bursts of random length
    // keep valid high back to back; between bursts drop valid for a random gap.
    task automatic send_block(input logic op, input logic [63:0] lo, input logic [63:0] hi,
                              input logic typed, input rsp_t want);
        req_valid      <= 1'b1;
        req.func       <= op;
        req.block_lo   <= lo;
        req.block_hi   <= hi;
        pend_typed     <= typed;
        pend_want      <= want;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        blocks_sent++;
        if (op == FUNC_ENC)
            enc_cnt++;
        else
            dec_cnt++;
        @(negedge clk);
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(negedge clk);
            burst_left = $urandom_range(0, 40);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic send_random_block();
        logic [63:0] lo;
        logic [63:0] hi;
        logic        op;
        rsp_t        ct;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        op = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            // all zeros
            0:
            begin
                lo = ZERO;
                hi = ZERO;
            end
            // all ones
            1:
            begin
                lo = ONES;
                hi = ONES;
            end
            // block equal to the key: whitening cancels to zero on encrypt
            2:
            begin
                lo = cur_key_lo;
                hi = cur_key_hi;
            end
            // single set bit anywhere in the block
            3:
            begin
                {hi, lo} = 128'h1 << $urandom_range(0, 127);
            end
            // decrypt a fresh ciphertext, which should give back random plaintext
            4, 5:
            begin
                ct = cipher_block(FUNC_ENC, lo, hi, {cur_key_hi, cur_key_lo}, cur_rounds);
                op = FUNC_DEC;
                lo = ct.result_lo;
                hi = ct.result_hi;
            end
            default: ;
        endcase
        send_block(op, lo, hi, MODEL, '0);
    endtask

    // Drop valid and hold off until the block owes nothing; every block
    // gives exactly one result, so an empty queue means the block is idle.
    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Response stall: switch at random between quiet, light, heavy and long-run
    // stall modes so stalls land on every stage of a block.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 400);
        end
        else
        begin
            mode_left--;
        end
        case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (run_left == 0)
                begin
                    stall_run = !stall_run;
                    run_left  = $urandom_range(1, 24);
                end
                run_left--;
                rsp_stall <= stall_run;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted block, check every accepted result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                if (pend_typed)
                    pending_results.push_back(pend_want);
                else
                    pending_results.push_back(cipher_block(req.func, req.block_lo,
                                                           req.block_hi,
                                                           {cur_key_hi, cur_key_lo},
                                                           cur_rounds));
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with nothing outstanding: result_lo %h result_hi %h",
                           rsp.result_lo, rsp.result_hi);
                    fail_cnt++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    checked_cnt++;
                    if (rsp.result_lo !== oldest.result_lo)
                    begin
                        $error("result_lo: expected %h, actual %h",
                               oldest.result_lo, rsp.result_lo);
                        fail_cnt++;
                    end
                    if (rsp.result_hi !== oldest.result_hi)
                    begin
                        $error("result_hi: expected %h, actual %h",
                               oldest.result_hi, rsp.result_hi);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rsp_t        want;
        logic [63:0] klo;
        logic [63:0] khi;
        logic [7:0]  rounds;
        int          count;
        int          phase;

        // Every input known from time zero
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        req_valid  = 1'b0;
        req        = '0;
        rsp_stall  = 1'b0;
        pend_typed = 1'b0;
        pend_want  = '0;
        burst_left = 0;
        fail_cnt   = 0;
        blocks_sent = 0;
        enc_cnt    = 0;
        dec_cnt    = 0;
        checked_cnt = 0;
        setting_cnt = 1;
        cycle_cnt  = 0;
        stall_mode = STALL_NONE;
        mode_left  = 0;
        run_left   = 0;
        stall_run  = 1'b0;
        cur_key_lo = ZERO;
        cur_key_hi = ZERO;
        cur_rounds = 8'd1;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers come out of reset with a zero key and one round
        check_reg(REG_KEY_LOW, ZERO, "key_low");
        check_reg(REG_KEY_HIGH, ZERO, "key_high");
        check_reg(REG_ROUND_COUNT, 64'd1, "round_count");

        // Directed rows; change the round count only once the block is idle
        for (int v = 0; v < NUM_VECTORS; v++)
        begin
            if (vectors[v].rounds != cur_rounds)
            begin
                drain_results();
                write_reg(REG_ROUND_COUNT, {56'h0, vectors[v].rounds});
                setting_cnt++;
            end
            want.result_lo = vectors[v].want_lo;
            want.result_hi = vectors[v].want_hi;
            send_block(vectors[v].op, vectors[v].lo, vectors[v].hi,
                       vectors[v].typed, want);
        end

        // Random phases: the first few pin the key and round-count extremes,
        // the rest use random keys and mostly small round counts to keep the
        // run short. Each phase starts with the block fully drained.
        phase = 0;
        while (blocks_sent < ITEM_TARGET)
        begin
            drain_results();
            case (phase)
                0:
                begin
                    klo = ONES;
                    khi = ONES;
                    rounds = 8'd255;
                    count = 4;
                end
                1:
                begin
                    klo = ZERO;
                    khi = ZERO;
                    rounds = 8'd0;
                    count = 100;
                end
                2:
                begin
                    klo = 64'h5555_5555_5555_5555;
                    khi = 64'haaaa_aaaa_aaaa_aaaa;
                    rounds = 8'd1;
                    count = 100;
                end
                3:
                begin
                    klo = {$urandom, $urandom};
                    khi = {$urandom, $urandom};
                    rounds = 8'd255;
                    count = 4;
                end
                default:
                begin
                    klo = {$urandom, $urandom};
                    khi = {$urandom, $urandom};
                    if ($urandom_range(0, 7) == 0)
                        rounds = 8'($urandom_range(6, 20));
                    else
                        rounds = 8'($urandom_range(0, 5));
                    count = $urandom_range(80, 160);
                end
            endcase
            load_cipher(klo, khi, rounds);
            repeat (count) send_random_block();
            phase++;
        end

        // Wait out the last results, then give a stray result time to show
        drain_results();
        repeat (17 * cur_rounds + 20) @(negedge clk);

        $display("Covered %0d blocks (%0d encrypt, %0d decrypt) under %0d key/round settings",
                 blocks_sent, enc_cnt, dec_cnt, setting_cnt);
        $display("Round counts 0, 255 and small random values run; %0d results compared, %0d errors",
                 checked_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[arx_block_cipher_16byte.f]
rtl/core/arx_pkg.sv
rtl/core/arx_cfg_regs.sv
rtl/core/arx_mix_unit.sv
rtl/core/arx_block_cipher_16byte.sv
verif/tb.sv
